/* src/spd_pkg.sv */
// Shared constants and types for the shortest path distances block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;
    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 256;
    localparam int WeightBits  = 16;
    localparam int VtxW  = 6;
    localparam int EdgeW = 8;
    localparam int CntW  = 9;
    localparam int DistW = 30;
    localparam logic [DistW-1:0] Unreached = 30'd1000000000;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RUN   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SCAN_RD, S_SCAN, S_PICK,
        S_EDGE_RD, S_EDGE, S_RELAX_WB, S_OUT_RD, S_OUT
    } t_state;
endpackage
`default_nettype wire

/* src/shortest_path_distances_core.sv */
// Top level: edge store, per-vertex scratch memories and the run sequencer.
// Depends on spd_pkg.
//
// channel | direction | handshake      | payload
// in      | input     | valid / stall  | op, vertex_a, vertex_b, weight, source
// out     | output    | valid / stall  | vertex, distance, reached, parent, ...
// cfg     | input     | valid / ready  | num_vertices
//
// Add and clear never raise the input stall. A run initializes n vertices.
// Each pick round scans all n vertices through the one-port scratch memory (a
// read state and a scan state per vertex), then a pick state; a round that
// settles a vertex then walks all E stored edges (a read state and an edge
// state each, plus a write-back state for each edge to another vertex).
// Rounds are the reached vertices plus one final empty round. Each result
// passes through an out-read state and an out state. Results go through one
// output register; a stall holds the sequencer. The input stalls from a run's
// acceptance until its last result is loaded. Synchronous active-low reset
// clears control state and sets num_vertices to 64.
`timescale 1ns / 1ps
`default_nettype none
module shortest_path_distances_core (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [1:0]               i_op,
    input  wire logic [spd_pkg::VtxW-1:0] i_vertex_a,
    input  wire logic [spd_pkg::VtxW-1:0] i_vertex_b,
    input  wire logic [15:0]              i_weight,
    input  wire logic [spd_pkg::VtxW-1:0] i_source,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [6:0]               i_cfg_num_vertices,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [spd_pkg::VtxW-1:0]      o_vertex,
    output logic [spd_pkg::DistW-1:0]     o_distance,
    output logic                          o_reached,
    output logic [spd_pkg::VtxW-1:0]      o_parent,
    output logic                          o_has_parent,
    output logic                          o_last
);
    import spd_pkg::*;

    // Edge memory: {a, b, len}
    localparam int EdgeBits = 2*VtxW + WeightBits;
    logic [EdgeBits-1:0] m_edge [MaxEdges];
    logic [EdgeBits-1:0] r_edge_q;
    // Vertex memory: {settled, pvalid, pred, dist}
    localparam int VBits = 2 + VtxW + DistW;
    logic [VBits-1:0] m_vtx [MaxVertices];
    logic [VBits-1:0] r_vtx_q;

    t_state r_state, n_state;
    logic [6:0]      r_nv;
    logic [CntW-1:0] r_held;
    logic [VtxW-1:0] r_src, r_v, r_pick;
    logic [EdgeW-1:0] r_e;
    logic            r_found;
    logic [DistW-1:0] r_pick_d, r_best;
    logic [6:0]      n_eff;
    // {pvalid, pred} of the best candidate, kept so the pick write preserves it
    logic [VtxW+1-1:0] r_pick_pp;

    // edge fields
    logic [VtxW-1:0] e_a, e_b, e_other;
    logic [WeightBits-1:0] e_len;
    logic            e_hit;
    logic [DistW:0]  cand;

    always_comb begin
        if (r_nv == 7'd0) n_eff = 7'd1;
        else if (r_nv > 7'(MaxVertices)) n_eff = 7'(MaxVertices);
        else n_eff = r_nv;
    end

    assign e_a   = r_edge_q[EdgeBits-1 -: VtxW];
    assign e_b   = r_edge_q[WeightBits +: VtxW];
    assign e_len = r_edge_q[WeightBits-1:0];
    assign e_hit = ({1'b0, e_a} < n_eff) && ({1'b0, e_b} < n_eff) &&
                   (e_a == r_pick || e_b == r_pick);
    assign e_other = (e_a == r_pick) ? e_b : e_a;
    assign cand = {1'b0, r_pick_d} + {{(DistW+1-WeightBits){1'b0}}, e_len};

    logic last_v, last_e, out_free;
    assign last_v   = ({1'b0, r_v} + 7'd1 == n_eff);
    assign last_e   = ({1'b0, r_e} + 9'd1 >= r_held);
    assign out_free = !o_valid || !i_stall;

    logic accept;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign accept      = i_valid && !o_stall;

    // vertex memory access control
    logic            v_we;
    logic [VtxW-1:0] v_addr;
    logic [VBits-1:0] v_wd;
    logic            v_settled, v_pv;
    logic [DistW-1:0] v_d;
    assign v_settled = r_vtx_q[VBits-1];
    assign v_pv      = r_vtx_q[VBits-2];
    assign v_d       = r_vtx_q[DistW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (accept && t_op'(i_op) == OP_RUN) n_state = S_INIT;
            S_INIT:     if (last_v) n_state = ({1'b0, r_src} < n_eff) ? S_SCAN_RD
                                                                       : S_OUT_RD;
            S_SCAN_RD:  n_state = S_SCAN;
            S_SCAN:     n_state = last_v ? S_PICK : S_SCAN_RD;
            S_PICK:     n_state = !r_found ? S_OUT_RD
                                 : (r_held == '0) ? S_SCAN_RD : S_EDGE_RD;
            S_EDGE_RD:  n_state = S_EDGE;
            S_EDGE: begin
                if (e_hit && e_other != r_pick) n_state = S_RELAX_WB;
                else n_state = last_e ? S_SCAN_RD : S_EDGE_RD;
            end
            S_RELAX_WB: n_state = last_e ? S_SCAN_RD : S_EDGE_RD;
            S_OUT_RD:   n_state = S_OUT;
            S_OUT:      if (out_free) n_state = last_v ? S_IDLE : S_OUT_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        v_we = 1'b0;
        v_addr = r_v;
        v_wd = r_vtx_q;
        case (r_state)
            S_INIT: begin
                v_we = 1'b1;
                v_wd = {2'b00, {VtxW{1'b0}}, (r_v == r_src) ? {DistW{1'b0}} : Unreached};
            end
            S_PICK: begin
                // settled mark set, stored predecessor kept
                v_addr = r_pick;
                v_we   = r_found;
                v_wd   = {1'b1, r_pick_pp, r_best};
            end
            S_EDGE:     v_addr = e_other;
            S_RELAX_WB: begin
                v_addr = r_v;
                v_we   = (cand < {1'b0, v_d});
                v_wd   = {v_settled, 1'b1, r_pick, cand[DistW-1:0]};
            end
            default: v_addr = r_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) m_vtx[v_addr] <= v_wd;
        r_vtx_q <= m_vtx[v_addr];
        if (accept && t_op'(i_op) == OP_ADD && r_held < 9'(MaxEdges) &&
            {1'b0, i_vertex_a} < n_eff && {1'b0, i_vertex_b} < n_eff)
            m_edge[r_held[EdgeW-1:0]] <= {i_vertex_a, i_vertex_b, i_weight[WeightBits-1:0]};
        r_edge_q <= m_edge[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nv    <= 7'd64;
            r_held  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_nv <= i_cfg_num_vertices;
            if (accept && t_op'(i_op) == OP_ADD && r_held < 9'(MaxEdges) &&
                {1'b0, i_vertex_a} < n_eff && {1'b0, i_vertex_b} < n_eff)
                r_held <= r_held + 9'd1;
            if (accept && t_op'(i_op) == OP_CLEAR) r_held <= '0;
            if (out_free) o_valid <= (r_state == S_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_v <= '0;
                r_src <= i_source;
            end
            S_INIT: begin
                r_v <= last_v ? '0 : r_v + 6'd1;
                r_found <= 1'b0;
            end
            S_SCAN: begin
                if (!v_settled && v_d < Unreached && (!r_found || v_d < r_best)) begin
                    r_found   <= 1'b1;
                    r_best    <= v_d;
                    r_pick    <= r_v;
                    r_pick_pp <= r_vtx_q[VBits-2 -: VtxW+1];
                end
                r_v <= last_v ? '0 : r_v + 6'd1;
            end
            S_PICK: begin
                // next round starts a fresh search
                r_pick_d <= r_best;
                r_e <= '0;
                r_v <= '0;
                r_found <= 1'b0;
            end
            S_EDGE: begin
                if (e_hit && e_other != r_pick) r_v <= e_other;
                else begin
                    r_e <= r_e + 8'd1;
                    if (last_e) r_v <= '0;
                end
            end
            S_RELAX_WB: begin
                r_e <= r_e + 8'd1;
                if (last_e) begin r_v <= '0; r_found <= 1'b0; end
            end
            S_OUT: if (out_free) r_v <= r_v + 6'd1;
            default: ;
        endcase
        if (r_state == S_OUT && out_free) begin
            o_vertex     <= r_v;
            o_distance   <= v_d;
            o_reached    <= (v_d < Unreached);
            o_parent     <= v_pv ? r_vtx_q[DistW +: VtxW] : '0;
            o_has_parent <= v_pv;
            o_last       <= last_v;
        end
    end
endmodule
`default_nettype wire

/* src/spd_checker.sv */
// Port-level checker for shortest_path_distances_core, bound to the top level.
// Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_cfg_ready,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_last,
    input wire logic o_reached,
    input wire logic o_has_parent
);
    import spd_pkg::*;
    a_par: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_parent |-> o_reached) else $error("parent without reach");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_stall) else $error("cfg ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_last) && $stable(o_reached) &&
                               $stable(o_has_parent))
        else $error("stalled result changed");
endmodule

bind shortest_path_distances_core spd_checker u_spd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_cfg_ready(o_cfg_ready), .o_valid(o_valid), .i_stall(i_stall),
    .o_last(o_last), .o_reached(o_reached), .o_has_parent(o_has_parent)
);
`default_nettype wire

/* test/testbench.sv */
// Testbench for shortest_path_distances_core: drives add, run and clear items,
// predicts per-vertex distances with its own Dijkstra model and checks results.
// Depends on spd_pkg and shortest_path_distances_core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import spd_pkg::*;

    typedef struct packed {
        t_op        op;
        logic [5:0] va;
        logic [5:0] vb;
        logic [15:0] weight;
        logic [5:0] src;
    } graph_item_t;

    typedef struct packed {
        logic [5:0]  vertex;
        logic [29:0] distance;
        logic        reached;
        logic [5:0]  parent;
        logic        has_parent;
        logic        last;
    } vertex_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_op = '0;
    logic [5:0] i_vertex_a = '0, i_vertex_b = '0, i_source = '0;
    logic [15:0] i_weight = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [6:0] i_cfg_num_vertices = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [5:0] o_vertex, o_parent;
    logic [29:0] o_distance;
    logic o_reached, o_has_parent, o_last;

    shortest_path_distances_core i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_vertex_a, .i_vertex_b,
        .i_weight, .i_source, .i_cfg_valid, .o_cfg_ready, .i_cfg_num_vertices,
        .o_valid, .i_stall, .o_vertex, .o_distance, .o_reached, .o_parent,
        .o_has_parent, .o_last
    );

    always #5 i_clk = ~i_clk;

    // predictor state: edge store and vertex count
    logic [5:0]  edge_a [MaxEdges];
    logic [5:0]  edge_b [MaxEdges];
    logic [15:0] edge_len [MaxEdges];
    int          edge_count;
    int          vertex_count;

    graph_item_t    pending_items[$];
    vertex_result_t expected_vertices[$];
    int errors, items_sent, results_seen, runs_sent;
    bit hold_off;   // long receiver stall requested by the stimulus

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    task automatic queue_item(input graph_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // Dijkstra on the model's edge store; queues the per-vertex results.
    task automatic predict_paths(input logic [5:0] src);
        logic [30:0] path_len [MaxVertices];
        logic [5:0]  pred [MaxVertices];
        bit          has_pred [MaxVertices];
        bit          done [MaxVertices];
        int n, pick, v, e;
        logic [30:0] cand;
        vertex_result_t r;
        n = vertex_count;
        for (v = 0; v < n; v++) begin
            path_len[v] = Unreached; pred[v] = '0; has_pred[v] = 0; done[v] = 0;
        end
        if (src < n) begin
            path_len[src] = 0;
            forever begin
                pick = n;
                for (v = 0; v < n; v++)
                    if (!done[v] && path_len[v] < Unreached &&
                        (pick == n || path_len[v] < path_len[pick]))
                        pick = v;
                if (pick == n) break;
                done[pick] = 1;
                for (e = 0; e < edge_count; e++) begin
                    if (edge_a[e] >= n || edge_b[e] >= n) continue;
                    cand = path_len[pick] + edge_len[e];
                    if (edge_a[e] == pick && cand < path_len[edge_b[e]]) begin
                        path_len[edge_b[e]] = cand; pred[edge_b[e]] = 6'(pick);
                        has_pred[edge_b[e]] = 1;
                    end
                    cand = path_len[pick] + edge_len[e];
                    if (edge_b[e] == pick && cand < path_len[edge_a[e]]) begin
                        path_len[edge_a[e]] = cand; pred[edge_a[e]] = 6'(pick);
                        has_pred[edge_a[e]] = 1;
                    end
                end
            end
        end
        for (v = 0; v < n; v++) begin
            r.vertex = 6'(v);
            r.distance = path_len[v][29:0];
            r.reached = path_len[v] < Unreached;
            r.parent = has_pred[v] ? pred[v] : 6'd0;
            r.has_parent = has_pred[v];
            r.last = (v == n - 1);
            expected_vertices.insert(expected_vertices.size(), r);
        end
    endtask

    task automatic apply_item(input graph_item_t it);
        case (it.op)
            OP_ADD: if (edge_count < MaxEdges && it.va < vertex_count && it.vb < vertex_count) begin
                edge_a[edge_count] = it.va;
                edge_b[edge_count] = it.vb;
                edge_len[edge_count] = it.weight;
                edge_count++;
            end
            OP_CLEAR: edge_count = 0;
            OP_RUN: begin
                runs_sent++;
                predict_paths(it.src);
            end
            default: ;
        endcase
    endtask

    // handshake sampled at the rising edge; prediction on acceptance
    logic item_taken = 1'b0;
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            apply_item({t_op'(i_op), i_vertex_a, i_vertex_b, i_weight, i_source});
            items_sent++;
        end
    end

    // driver: one item at a time, random gap before each
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && item_taken) begin
                i_valid <= 1'b0;
            end else if (!i_valid) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                else if (pending_items.size() > 0) begin
                    graph_item_t it;
                    it = pending_items.pop_front();
                    i_op <= it.op; i_vertex_a <= it.va; i_vertex_b <= it.vb;
                    i_weight <= it.weight; i_source <= it.src;
                    i_valid <= 1'b1;
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                end
            end
        end
    end

    // receiver stall: random per result, plus a long hold when asked
    int stall_left = 0;
    int hold_cycles = 0;
    int stall_draw;
    logic result_taken = 1'b0;
    always @(negedge i_clk) begin
        if (hold_off && hold_cycles < 3000) begin
            hold_cycles <= hold_cycles + 1;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (result_taken) begin
            stall_draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
            i_stall <= (stall_draw > 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        vertex_result_t want;
        result_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_vertices.size() == 0) begin
                report("unexpected result for vertex", 32'(o_vertex), 32'd0);
            end else begin
                want = expected_vertices.pop_front();
                if (o_vertex !== want.vertex) report("vertex", o_vertex, want.vertex);
                if (o_distance !== want.distance) report("distance", o_distance, want.distance);
                if (o_reached !== want.reached) report("reached", o_reached, want.reached);
                if (o_parent !== want.parent) report("parent", o_parent, want.parent);
                if (o_has_parent !== want.has_parent)
                    report("has_parent", o_has_parent, want.has_parent);
                if (o_last !== want.last) report("last", o_last, want.last);
            end
        end
    end

    function automatic graph_item_t make_item(t_op op, int a, int b, int w, int s);
        graph_item_t it;
        it.op = op; it.va = 6'(a); it.vb = 6'(b); it.weight = 16'(w); it.src = 6'(s);
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_vertices.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input int value);
        @(negedge i_clk);
        i_cfg_num_vertices <= 7'(value);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        vertex_count = (value == 0) ? 1 : (value > MaxVertices ? MaxVertices : value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random graph phase: mostly edges inside range, mixed with runs, clears and odd items
    task automatic random_phase(input int count);
        int k, n;
        n = vertex_count;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0: queue_item(make_item(OP_CLEAR, 0, 0, 0, 0));
                1: queue_item(make_item(OP_NONE, $urandom, $urandom, $urandom, $urandom));
                2, 3, 4: queue_item(make_item(OP_RUN, 0, 0, 0,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, n - 1)));
                5: queue_item(make_item(OP_ADD, $urandom, $urandom, $urandom, $urandom));
                default: queue_item(make_item(OP_ADD,
                    $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                    ($urandom_range(0, 1)) ? $urandom_range(0, 65535) : $urandom_range(0, 20),
                    $urandom));
            endcase
        end
    endtask

    initial begin
        int k;
        edge_count = 0; vertex_count = MaxVertices;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: full size graph, extremes, self loop, odd source, op 3
        queue_item(make_item(OP_RUN, 0, 0, 0, 0));
        queue_item(make_item(OP_ADD, 0, 63, 16'hFFFF, 0));
        queue_item(make_item(OP_ADD, 63, 62, 0, 63));
        queue_item(make_item(OP_ADD, 5, 5, 7, 0));
        queue_item(make_item(OP_ADD, 62, 0, 16'hFFFF, 0));
        queue_item(make_item(OP_ADD, 1, 2, 1, 0));
        queue_item(make_item(OP_NONE, 1, 0, 3, 0));
        queue_item(make_item(OP_RUN, 0, 0, 0, 63));
        queue_item(make_item(OP_RUN, 0, 0, 0, 1));
        drain();

        write_vertex_count(1);
        queue_item(make_item(OP_ADD, 0, 0, 9, 0));
        queue_item(make_item(OP_ADD, 0, 1, 9, 0));
        queue_item(make_item(OP_RUN, 0, 0, 0, 0));
        queue_item(make_item(OP_RUN, 0, 0, 0, 5));
        queue_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        drain();

        write_vertex_count(0);
        queue_item(make_item(OP_RUN, 0, 0, 0, 0));
        drain();
        write_vertex_count(100);
        queue_item(make_item(OP_RUN, 0, 0, 0, 62));
        drain();

        // small dense graph with parallel edges and self loops
        write_vertex_count(4);
        for (k = 0; k < 12; k++)
            queue_item(make_item(OP_ADD, $urandom_range(0, 3), $urandom_range(0, 3),
                                 $urandom, 0));
        queue_item(make_item(OP_RUN, 0, 0, 0, 2));
        queue_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        drain();

        // long receiver hold while runs keep arriving
        write_vertex_count(8);
        hold_off = 1;
        for (k = 0; k < 4; k++) queue_item(make_item(OP_RUN, 0, 0, 0, k));
        random_phase(10);
        drain();
        hold_off = 0;

        write_vertex_count(8);  random_phase(25); drain();
        write_vertex_count(16); random_phase(25); drain();
        write_vertex_count(3);  random_phase(20); drain();
        write_vertex_count(64); random_phase(15); drain();

        $display("covered %0d items with %0d runs, %0d vertex results checked",
                 items_sent, runs_sent, results_seen);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
